FILE: sv/rpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpb_pkg
// Shared constants, types and helpers of the radial profile binner.
// ----------------------------------------------------------------------------
package rpb_pkg;

   localparam int GRID_MAX  = 64;
   localparam int NUM_BINS  = 64;
   localparam int BIN_W     = 6;
   localparam int POS_W     = 6;
   localparam int GDIM_W    = 7;
   localparam int CNT_W     = 19;
   localparam int D2_W      = 16;
   localparam int DIV_STEPS = 64;
   localparam int MUL_STEPS = 96;
   localparam int ISQ_STEPS = 8;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
   localparam logic [31:0]      M32       = 32'hFFFF_FFFF;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   localparam logic [1:0] REG_GRID_X = 2'd0;
   localparam logic [1:0] REG_GRID_Y = 2'd1;
   localparam logic [1:0] REG_GRID_Z = 2'd2;

   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic [63:0]      tsum;
      logic [63:0]      dsum;
      logic [63:0]      ssum;
   } entry_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quot;
   } div_rsp_type;

   function automatic logic [GDIM_W-1:0] clamp_grid(input logic [GDIM_W-1:0] g);
      logic [GDIM_W-1:0] r;
      r = g;
      if (g == '0) r = GDIM_W'(1);
      else if (g > GDIM_W'(GRID_MAX)) r = GDIM_W'(GRID_MAX);
      return r;
   endfunction

   function automatic logic [31:0] abs32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [13:0] sq_off(input logic [POS_W-1:0] p,
                                          input logic [GDIM_W-1:0] g);
      logic [GDIM_W-1:0] a;
      logic [GDIM_W-1:0] d;
      logic [13:0]       dw;
      a = {p, 1'b0};
      d = (a >= g) ? (a - g) : (g - a);
      dw = {7'd0, d};
      return dw * dw;
   endfunction

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

endpackage

FILE: sv/rpb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpb_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend over a
// 32-bit divisor, quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
module rpb_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rpb_pkg::div_req_type req,
   output rpb_pkg::div_rsp_type rsp
);

   logic [32:0] rem_ff, rem_in;
   logic [63:0] dq_ff, dq_in;
   logic [31:0] dsr_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [32:0] rem_sh;
   logic        qbit;

   always_comb begin
      rem_sh = {rem_ff[31:0], dq_ff[63]};
      qbit   = (rem_sh >= {1'b0, dsr_ff});
      rem_in = qbit ? (rem_sh - {1'b0, dsr_ff}) : rem_sh;
      dq_in  = {dq_ff[62:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(rpb_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start && !busy_ff) begin
         rem_ff <= '0;
         dq_ff  <= req.dividend;
         dsr_ff <= req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = (|dq_ff[63:32]) ? rpb_pkg::M32 : dq_ff[31:0];

endmodule

FILE: sv/radial_profile_binner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_profile_binner_unit
// Radial profile of a 3-D grid: per-bin cell counts and mean temperature,
// density and squared speed.
// ----------------------------------------------------------------------------
// Channels: req_* carries one item (sample, read or clear); rsp_* returns one
// item per read. Both use valid/stall. csr_* sets grid_x/y/z at 0x0/0x4/0x8.
// A sample item runs the bit-serial velocity squares (three shift-add
// passes), while the divider forms the temperature and an 8-step square
// root forms the bin, then a read and a write of the bin memory. A read
// item reads the bin memory, then forms each of the three means with the
// divider (none for an empty bin), then loads the output register.
// Clear items and unknown kinds do not leave the idle state.
// Items are taken one at a time; req_stall stays high while one is at work.
// Reset clears the position, sets the grid to 64 and marks all bins empty
// through per-bin valid bits; no clearing pass is needed.
// A stalled result holds in the output register; samples and clears are
// still taken, a further read waits until the register is free.
// ----------------------------------------------------------------------------
module radial_profile_binner_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [31:0]        req_density,
   input  logic [31:0]        req_pressure,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic [5:0]         req_read_bin,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_bin_index,
   output logic [18:0]        rsp_cell_count,
   output logic [31:0]        rsp_mean_temperature,
   output logic [31:0]        rsp_mean_density,
   output logic [31:0]        rsp_mean_speed_sq,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SMP  = 3'd1;
   localparam logic [2:0] ST_SRD  = 3'd2;
   localparam logic [2:0] ST_SWR  = 3'd3;
   localparam logic [2:0] ST_RRD  = 3'd4;
   localparam logic [2:0] ST_RLD  = 3'd5;
   localparam logic [2:0] ST_RDIV = 3'd6;
   localparam logic [2:0] ST_ROUT = 3'd7;

   localparam int BW = rpb_pkg::BIN_W;
   localparam int PW = rpb_pkg::POS_W;
   localparam int GW = rpb_pkg::GDIM_W;
   localparam int DW = rpb_pkg::D2_W;

   logic [2:0]  state_ff;
   logic [GW-1:0] gx_ff, gy_ff, gz_ff;
   logic [GW-1:0] gx, gy, gz;
   logic [PW-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [rpb_pkg::NUM_BINS-1:0] vld_ff;
   logic [6:0]  step_ff;
   logic [15:0] isq_v_ff, isq_res_ff, isq_bit_ff;
   logic [15:0] isq_sum;
   logic [63:0] mcand_ff, acc_ff;
   logic [31:0] mplier_ff, absy_ff, absz_ff, rho_ff;
   logic [BW-1:0] bin_ff, read_bin_ff, rd_addr;
   logic [BW-1:0] bin_in;
   logic [DW-1:0] d2;
   logic [1:0]  part_ff;
   logic        rd_vld_ff;
   rpb_pkg::entry_type mem [rpb_pkg::NUM_BINS];
   rpb_pkg::entry_type rd_ent_ff, rd_eff, ent_ff, wr_ent_in;
   logic        wr_en;
   logic [31:0] mean_t_ff, mean_d_ff, mean_s_ff;
   logic [31:0] spd;
   logic        rsp_valid_ff;
   logic [BW-1:0] rsp_bin_ff;
   logic [rpb_pkg::CNT_W-1:0] rsp_cnt_ff;
   logic [31:0] rsp_t_ff, rsp_d_ff, rsp_s_ff;
   logic        acc_req, acc_smp, cfg_wr, out_free;
   logic [PW:0] px_inc, py_inc, pz_inc;
   rpb_pkg::div_req_type div_req;
   rpb_pkg::div_rsp_type div_rsp;

   rpb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign gx = rpb_pkg::clamp_grid(gx_ff);
   assign gy = rpb_pkg::clamp_grid(gy_ff);
   assign gz = rpb_pkg::clamp_grid(gz_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign acc_req   = req_valid && !req_stall;
   assign acc_smp   = acc_req && (req_kind == rpb_pkg::KIND_SAMPLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cfg_wr    = csr_psel && csr_penable && csr_pwrite;

   assign d2 = DW'(rpb_pkg::sq_off(pos_x_ff, gx)) + DW'(rpb_pkg::sq_off(pos_y_ff, gy))
             + DW'(rpb_pkg::sq_off(pos_z_ff, gz));

   assign px_inc = {1'b0, pos_x_ff} + 7'd1;
   assign py_inc = {1'b0, pos_y_ff} + 7'd1;
   assign pz_inc = {1'b0, pos_z_ff} + 7'd1;

   assign isq_sum = isq_res_ff + isq_bit_ff;
   assign bin_in  = (|isq_res_ff[15:BW+1]) ? {BW{1'b1}} : isq_res_ff[BW:1];

   assign rd_eff = rd_vld_ff ? rd_ent_ff : '0;
   assign spd    = (|acc_ff[63:48]) ? rpb_pkg::M32 : acc_ff[47:16];
   assign rd_addr = (state_ff == ST_SRD) ? bin_ff : read_bin_ff;

   always_comb begin
      wr_en          = (state_ff == ST_SWR) && (rd_eff.cnt != rpb_pkg::COUNT_MAX);
      wr_ent_in.cnt  = rd_eff.cnt + rpb_pkg::CNT_W'(1);
      wr_ent_in.tsum = rpb_pkg::sat_add(rd_eff.tsum, {32'd0, div_rsp.quot});
      wr_ent_in.dsum = rpb_pkg::sat_add(rd_eff.dsum, {32'd0, rho_ff});
      wr_ent_in.ssum = rpb_pkg::sat_add(rd_eff.ssum, {32'd0, spd});
   end

   always_comb begin
      div_req.start    = acc_smp
                       || ((state_ff == ST_RLD) && (rd_eff.cnt != '0))
                       || ((state_ff == ST_RDIV) && div_rsp.done && (part_ff != 2'd2));
      div_req.dividend = {16'd0, req_pressure, 16'd0};
      div_req.divisor  = req_density;
      if (state_ff == ST_RLD) begin
         div_req.dividend = rd_eff.tsum;
         div_req.divisor  = {13'd0, rd_eff.cnt};
      end else if (state_ff == ST_RDIV) begin
         div_req.dividend = (part_ff == 2'd0) ? ent_ff.dsum : ent_ff.ssum;
         div_req.divisor  = {13'd0, ent_ff.cnt};
      end
   end

   // bin memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[bin_ff] <= wr_ent_in;
      rd_ent_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gx_ff <= GW'(64);
         gy_ff <= GW'(64);
         gz_ff <= GW'(64);
      end else if (cfg_wr) begin
         case (csr_paddr[3:2])
            rpb_pkg::REG_GRID_X: gx_ff <= csr_pwdata[GW-1:0];
            rpb_pkg::REG_GRID_Y: gy_ff <= csr_pwdata[GW-1:0];
            rpb_pkg::REG_GRID_Z: gz_ff <= csr_pwdata[GW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         rpb_pkg::REG_GRID_X: csr_prdata = {25'd0, gx_ff};
         rpb_pkg::REG_GRID_Y: csr_prdata = {25'd0, gy_ff};
         rpb_pkg::REG_GRID_Z: csr_prdata = {25'd0, gz_ff};
         default:             csr_prdata = '0;
      endcase
   end
   assign csr_pready = 1'b1;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pos_z_ff     <= '0;
         vld_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         step_ff      <= '0;
         part_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[rd_addr];
         if ((state_ff == ST_ROUT) && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (acc_req) begin
                  case (req_kind)
                     rpb_pkg::KIND_SAMPLE: begin
                        state_ff <= ST_SMP;
                        step_ff  <= '0;
                        if (px_inc >= gx) begin
                           pos_x_ff <= '0;
                           if (py_inc >= gy) begin
                              pos_y_ff <= '0;
                              pos_z_ff <= (pz_inc >= gz) ? '0 : pz_inc[PW-1:0];
                           end else begin
                              pos_y_ff <= py_inc[PW-1:0];
                           end
                        end else begin
                           pos_x_ff <= px_inc[PW-1:0];
                        end
                     end
                     rpb_pkg::KIND_READ: state_ff <= ST_RRD;
                     rpb_pkg::KIND_CLEAR: begin
                        vld_ff   <= '0;
                        pos_x_ff <= '0;
                        pos_y_ff <= '0;
                        pos_z_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_SMP: begin
               step_ff <= step_ff + 7'd1;
               if (step_ff == 7'(rpb_pkg::MUL_STEPS - 1)) state_ff <= ST_SRD;
            end
            ST_SRD: state_ff <= ST_SWR;
            ST_SWR: begin
               if (wr_en) vld_ff[bin_ff] <= 1'b1;
               state_ff <= ST_IDLE;
            end
            ST_RRD: state_ff <= ST_RLD;
            ST_RLD: begin
               part_ff  <= '0;
               state_ff <= (rd_eff.cnt == '0) ? ST_ROUT : ST_RDIV;
            end
            ST_RDIV: begin
               if (div_rsp.done) begin
                  part_ff <= part_ff + 2'd1;
                  if (part_ff == 2'd2) state_ff <= ST_ROUT;
               end
            end
            ST_ROUT: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (acc_req) read_bin_ff <= req_read_bin;
      if (acc_smp) begin
         isq_v_ff   <= d2;
         isq_res_ff <= '0;
         isq_bit_ff <= 16'h4000;
         mcand_ff   <= {32'd0, rpb_pkg::abs32(req_vel_x)};
         mplier_ff  <= rpb_pkg::abs32(req_vel_x);
         absy_ff    <= rpb_pkg::abs32(req_vel_y);
         absz_ff    <= rpb_pkg::abs32(req_vel_z);
         acc_ff     <= '0;
         rho_ff     <= req_density;
      end else if (state_ff == ST_SMP) begin
         if (step_ff < 7'(rpb_pkg::ISQ_STEPS)) begin
            if (isq_v_ff >= isq_sum) begin
               isq_v_ff   <= isq_v_ff - isq_sum;
               isq_res_ff <= (isq_res_ff >> 1) + isq_bit_ff;
            end else begin
               isq_res_ff <= isq_res_ff >> 1;
            end
            isq_bit_ff <= isq_bit_ff >> 2;
         end
         if (step_ff == 7'(rpb_pkg::ISQ_STEPS)) bin_ff <= bin_in;
         if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
         if (step_ff[4:0] == 5'd31) begin
            mcand_ff  <= {32'd0, (step_ff[6:5] == 2'd0) ? absy_ff : absz_ff};
            mplier_ff <= (step_ff[6:5] == 2'd0) ? absy_ff : absz_ff;
         end else begin
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
         end
      end
      if (state_ff == ST_RLD) begin
         ent_ff    <= rd_eff;
         mean_t_ff <= '0;
         mean_d_ff <= '0;
         mean_s_ff <= '0;
      end
      if ((state_ff == ST_RDIV) && div_rsp.done) begin
         case (part_ff)
            2'd0:    mean_t_ff <= div_rsp.quot;
            2'd1:    mean_d_ff <= div_rsp.quot;
            default: mean_s_ff <= div_rsp.quot;
         endcase
      end
      if ((state_ff == ST_ROUT) && out_free) begin
         rsp_bin_ff <= read_bin_ff;
         rsp_cnt_ff <= ent_ff.cnt;
         rsp_t_ff   <= mean_t_ff;
         rsp_d_ff   <= mean_d_ff;
         rsp_s_ff   <= mean_s_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_bin_index        = rsp_bin_ff;
   assign rsp_cell_count       = rsp_cnt_ff;
   assign rsp_mean_temperature = rsp_t_ff;
   assign rsp_mean_density     = rsp_d_ff;
   assign rsp_mean_speed_sq    = rsp_s_ff;

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.busy |-> (state_ff == ST_SMP || state_ff == ST_RDIV))
      else $error("divider busy outside sample or mean phase");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (acc_req && req_kind == rpb_pkg::KIND_CLEAR) |=> (vld_ff == '0))
      else $error("clear left a bin valid");

   a_empty_means: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cell_count == '0) |->
      (rsp_mean_temperature == '0 && rsp_mean_density == '0 && rsp_mean_speed_sq == '0))
      else $error("empty bin returned nonzero mean");

endmodule

FILE: sim/radial_profile_binner_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_profile_binner_checker
// Tracks the grid registers from CSR writes and keeps its own copy of the
// per-bin counts, sums and cell position. Accepted sample and clear items
// update that copy. A read pushes the expected per-bin means, and each accepted
// response item is compared field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module radial_profile_binner_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_density,
   input  logic [31:0] req_pressure,
   input  logic [31:0] req_vel_x,
   input  logic [31:0] req_vel_y,
   input  logic [31:0] req_vel_z,
   input  logic [5:0]  req_read_bin,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [5:0]  rsp_bin_index,
   input  logic [18:0] rsp_cell_count,
   input  logic [31:0] rsp_mean_temperature,
   input  logic [31:0] rsp_mean_density,
   input  logic [31:0] rsp_mean_speed_sq,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          pending,
   output int          failures
);

   typedef struct {
      logic [5:0]  bin_index;
      logic [18:0] cell_count;
      logic [31:0] mean_temperature;
      logic [31:0] mean_density;
      logic [31:0] mean_speed_sq;
   } bin_means_type;

   bin_means_type mean_queue[$];
   logic [6:0]  grid_reg[3];
   logic [18:0] counts[rpb_pkg::NUM_BINS];
   logic [63:0] temp_sums[rpb_pkg::NUM_BINS];
   logic [63:0] dens_sums[rpb_pkg::NUM_BINS];
   logic [63:0] spd_sums[rpb_pkg::NUM_BINS];
   logic [5:0]  pos[3];

   function automatic int clamped(input logic [6:0] g);
      if (g == 0) return 1;
      if (g > rpb_pkg::GRID_MAX) return rpb_pkg::GRID_MAX;
      return int'(g);
   endfunction

   function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   function automatic logic [63:0] vel_sq(input logic [31:0] v);
      logic [63:0] m;
      m = {32'd0, v[31] ? (~v + 32'd1) : v};
      return m * m;
   endfunction

   function automatic logic [31:0] mean_of(input logic [63:0] sum, input logic [18:0] n);
      logic [63:0] q;
      q = sum / {45'd0, n};
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function automatic void clear_bins();
      for (int i = 0; i < rpb_pkg::NUM_BINS; i++) begin
         counts[i] = '0;
         temp_sums[i] = '0;
         dens_sums[i] = '0;
         spd_sums[i] = '0;
      end
      for (int i = 0; i < 3; i++) pos[i] = '0;
   endfunction

   function automatic void bin_cell();
      int g[3];
      int d2;
      int a;
      int r;
      int bin;
      logic [63:0] temp;
      logic [63:0] spd;
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
         g[i] = clamped(grid_reg[i]);
         a = 2 * int'(pos[i]);
         d2 += (a >= g[i]) ? (a - g[i]) * (a - g[i]) : (g[i] - a) * (g[i] - a);
      end
      r = 0;
      while ((r + 1) * (r + 1) <= d2) r++;
      bin = r / 2;
      if (bin >= rpb_pkg::NUM_BINS) bin = rpb_pkg::NUM_BINS - 1;
      if (req_density == 0) begin
         temp = 64'hFFFF_FFFF;
      end else begin
         temp = ({32'd0, req_pressure} << 16) / {32'd0, req_density};
         if (temp > 64'hFFFF_FFFF) temp = 64'hFFFF_FFFF;
      end
      spd = (vel_sq(req_vel_x) + vel_sq(req_vel_y) + vel_sq(req_vel_z)) >> 16;
      if (spd > 64'hFFFF_FFFF) spd = 64'hFFFF_FFFF;
      if (counts[bin] < rpb_pkg::COUNT_MAX) begin
         counts[bin] = counts[bin] + 19'd1;
         temp_sums[bin] = add_sat(temp_sums[bin], temp);
         dens_sums[bin] = add_sat(dens_sums[bin], {32'd0, req_density});
         spd_sums[bin] = add_sat(spd_sums[bin], spd);
      end
      for (int i = 0; i < 3; i++) begin
         if (int'(pos[i]) + 1 >= g[i]) begin
            pos[i] = '0;
         end else begin
            pos[i] = pos[i] + 6'd1;
            break;
         end
      end
   endfunction

   always @(posedge clock) begin
      bin_means_type e;
      bin_means_type got;
      if (reset) begin
         mean_queue.delete();
         for (int i = 0; i < 3; i++) grid_reg[i] = 7'd64;
         clear_bins();
         failures = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               rpb_pkg::REG_GRID_X: grid_reg[0] = csr_pwdata[6:0];
               rpb_pkg::REG_GRID_Y: grid_reg[1] = csr_pwdata[6:0];
               rpb_pkg::REG_GRID_Z: grid_reg[2] = csr_pwdata[6:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_bin_index, rsp_cell_count, rsp_mean_temperature,
                    rsp_mean_density, rsp_mean_speed_sq};
            if (mean_queue.size() == 0) begin
               $error("unexpected response item, bin_index %0d", rsp_bin_index);
               failures++;
            end else begin
               e = mean_queue.pop_front();
               if (got.bin_index !== e.bin_index) begin
                  $error("bin_index: expected %0d, got %0d", e.bin_index, got.bin_index);
                  failures++;
               end
               if (got.cell_count !== e.cell_count) begin
                  $error("cell_count: expected %0d, got %0d", e.cell_count, got.cell_count);
                  failures++;
               end
               if (got.mean_temperature !== e.mean_temperature) begin
                  $error("mean_temperature: expected %h, got %h",
                         e.mean_temperature, got.mean_temperature);
                  failures++;
               end
               if (got.mean_density !== e.mean_density) begin
                  $error("mean_density: expected %h, got %h",
                         e.mean_density, got.mean_density);
                  failures++;
               end
               if (got.mean_speed_sq !== e.mean_speed_sq) begin
                  $error("mean_speed_sq: expected %h, got %h",
                         e.mean_speed_sq, got.mean_speed_sq);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_kind)
               rpb_pkg::KIND_SAMPLE: bin_cell();
               rpb_pkg::KIND_READ: begin
                  e.bin_index = req_read_bin;
                  e.cell_count = counts[req_read_bin];
                  if (e.cell_count == 0) begin
                     e.mean_temperature = '0;
                     e.mean_density = '0;
                     e.mean_speed_sq = '0;
                  end else begin
                     e.mean_temperature = mean_of(temp_sums[req_read_bin], e.cell_count);
                     e.mean_density = mean_of(dens_sums[req_read_bin], e.cell_count);
                     e.mean_speed_sq = mean_of(spd_sums[req_read_bin], e.cell_count);
                  end
                  mean_queue.push_back(e);
               end
               rpb_pkg::KIND_CLEAR: clear_bins();
               default: ;
            endcase
         end
      end
      pending = mean_queue.size();
   end

endmodule

FILE: sim/radial_profile_binner_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_profile_binner_unit_tb
// Drives directed and random sample, read and clear items through the binner
// over several grid settings, with random idle bursts on both channels, a
// long response hold-off and a drain pause. The checker predicts and compares;
// this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module radial_profile_binner_unit_tb;

   localparam int LIMIT = 3000000;
   localparam int SETTLE = 200;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [31:0] req_density;
   logic [31:0] req_pressure;
   logic [31:0] req_vel_x;
   logic [31:0] req_vel_y;
   logic [31:0] req_vel_z;
   logic [5:0]  req_read_bin;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [5:0]  rsp_bin_index;
   logic [18:0] rsp_cell_count;
   logic [31:0] rsp_mean_temperature;
   logic [31:0] rsp_mean_density;
   logic [31:0] rsp_mean_speed_sq;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          pending;
   int          failures;
   int          cycles;
   bit          quiet;
   bit          hold_rsp;
   int          stall_left;

   radial_profile_binner_unit dut (.*);

   radial_profile_binner_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("radial_profile_binner_unit_tb: FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_rsp) begin
         rsp_stall = 1'b1;
         repeat (600) @(negedge clock);
         hold_rsp = 1'b0;
         rsp_stall = 1'b0;
      end else if (quiet || reset) begin
         rsp_stall = 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         rsp_stall = 1'b0;
         if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 6);
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 6))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'hFFFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return $urandom_range(0, 32'h0004_0000);
         default: return $urandom;
      endcase
   endfunction

   task automatic send(input logic [1:0] kind, input logic [31:0] dens, input logic [31:0] prs,
                       input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz,
                       input logic [5:0] bin);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = kind;
      req_density = dens;
      req_pressure = prs;
      req_vel_x = vx;
      req_vel_y = vy;
      req_vel_z = vz;
      req_read_bin = bin;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_random(input int n);
      int k;
      logic [1:0] kind;
      logic [5:0] bin;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         kind = (k < 75) ? rpb_pkg::KIND_SAMPLE : (k < 95) ? rpb_pkg::KIND_READ :
                (k < 98) ? rpb_pkg::KIND_CLEAR : rpb_pkg::KIND_NONE;
         bin = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12));
         send(kind, pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), bin);
      end
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [6:0] value);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = {$urandom} & 32'hFFFF_FF80 | {25'd0, value};
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic set_grid(input logic [6:0] gx, input logic [6:0] gy, input logic [6:0] gz);
      csr_write(rpb_pkg::REG_GRID_X, gx);
      csr_write(rpb_pkg::REG_GRID_Y, gy);
      csr_write(rpb_pkg::REG_GRID_Z, gz);
   endtask

   initial begin
      cycles = 0;
      quiet = 1'b0;
      hold_rsp = 1'b0;
      stall_left = 0;
      reset = 1'b1;
      rsp_stall = 1'b0;
      req_valid = 1'b0;
      req_kind = rpb_pkg::KIND_SAMPLE;
      req_density = '0;
      req_pressure = '0;
      req_vel_x = '0;
      req_vel_y = '0;
      req_vel_z = '0;
      req_read_bin = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      send(rpb_pkg::KIND_READ, 0, 0, 0, 0, 0, 6'd63);
      send(rpb_pkg::KIND_SAMPLE, 32'd0, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000,
           32'h8000_0000, 0);
      send(rpb_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
           32'h7FFF_FFFF, 0);
      send(rpb_pkg::KIND_SAMPLE, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1, 0);
      send(rpb_pkg::KIND_SAMPLE, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000,
           0, 0);
      send(rpb_pkg::KIND_READ, 0, 0, 0, 0, 0, 6'd55);
      send(rpb_pkg::KIND_READ, 0, 0, 0, 0, 0, 6'd54);
      send(rpb_pkg::KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
           32'hFFFF_FFFF, 6'd63);
      send(rpb_pkg::KIND_READ, 0, 0, 0, 0, 0, 6'd55);
      send(rpb_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0);
      send(rpb_pkg::KIND_READ, 0, 0, 0, 0, 0, 6'd55);
      send(rpb_pkg::KIND_READ, 0, 0, 0, 0, 0, 6'd0);
      drain();

      set_grid(7'd2, 7'd2, 7'd2);
      send_random(300);
      drain();

      set_grid(7'd0, 7'd1, 7'd1);
      send_random(150);
      hold_rsp = 1'b1;
      send_random(150);
      drain();

      set_grid(7'd127, 7'd3, 7'd65);
      send_random(300);
      drain();

      set_grid(7'd5, 7'd4, 7'd3);
      send_random(300);
      drain();

      set_grid(7'd64, 7'd2, 7'd1);
      send_random(300);
      drain();

      set_grid(7'd3, 7'd64, 7'd2);
      quiet = 1'b1;
      send_random(300);
      drain();

      if (failures == 0) begin
         $display("radial_profile_binner_unit_tb: PASS");
      end else begin
         $display("radial_profile_binner_unit_tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/rpb_pkg.sv
sv/rpb_div.sv
sv/radial_profile_binner_unit.sv
sim/radial_profile_binner_checker.sv
sim/radial_profile_binner_unit_tb.sv
